### sv/nls_pkg.sv
package nls_pkg;

  // Q2.30 and Q16.16 scaling
  localparam int unsigned Q30_FRAC = 30;
  localparam int unsigned V_FRAC   = 16;
  localparam logic [31:0] V_ONE    = 32'h0001_0000;
  localparam logic [31:0] V_TWO    = 32'h0002_0000;

  // Datapath widths
  localparam int unsigned MAG_W = 31;  // magnitudes up to 1.0 in Q2.30
  localparam int unsigned DVD_W = 62;  // widest dividend: (v - 1.0) << 30
  localparam int unsigned DVS_W = 32;  // widest divisor: v
  localparam int unsigned CNT_W = 16;
  localparam int unsigned TOL_W = 30;
  localparam int unsigned SUM_W = 36;
  localparam int unsigned STP_W = 6;

  // Divider step counts
  localparam logic [STP_W-1:0] STEPS_LONG  = STP_W'(DVD_W);
  localparam logic [STP_W-1:0] STEPS_SHORT = STP_W'(MAG_W);

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0] TERM_LIMIT_RST = 16'd9749;
  localparam logic [TOL_W-1:0] TOLERANCE_RST  = 30'd1360;

  // Register indexes
  localparam logic REG_TERM_LIMIT = 1'b0;
  localparam logic REG_TOLERANCE  = 1'b1;

  // Request to the serial divider
  typedef struct packed {
    logic              start;
    logic              long_div;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  // Status back from the serial divider
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [MAG_W-1:0]  quotient;
  } div_rsp_t;

endpackage

### sv/nls_div.sv
module nls_div import nls_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [STP_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DVS_W:0]   rem_shift;
  logic [DVS_W+1:0] diff;
  logic             ge;

  // One restoring step: shift in the next dividend bit, try subtract
  assign rem_shift = {rem_q, dvd_q[DVD_W-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, dvs_q};
  assign ge        = ~diff[DVS_W+1];

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = req_i.long_div ? STEPS_LONG : STEPS_SHORT;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - STP_W'(1);
      if (cnt_q == STP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q[MAG_W-1:0];

`ifndef NO_ASSERTIONS
  // A finished division is never still counting
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");

  // A started division runs at least one step
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("divider did not start");

  // The step counter is spent exactly when the unit finishes
  a_done_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && cnt_q == STP_W'(1)) |=> done_q)
    else $error("divider missed its last step");
`endif

endmodule

### sv/natural_log_series.sv
// Channel     | Dir | Fields (low bit up)
// s_axis      | in  | tdata: value[31:0]
// m_axis      | out | tdata: ln_value[31:0], terms_used[47:32]; tuser: bad_input
// apb cfg     | in  | 0x0 term_limit[15:0], 0x4 tolerance[29:0]
//
// Each series term passes through one check, one multiply and a division in
// the shared bit-serial divider; when v > 2, the same divider first forms
// x = (1 - v) / v up front. The divider sets the rate.
// s_axis_tready_o is high only while the sequencer is idle.
// A finished result waits in the output register; a new item may be taken
// meanwhile. Reset restores the register defaults; no clearing pass.
module natural_log_series import nls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // value[31:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // ln_value[31:0], terms_used[47:32]
  output logic        m_axis_tuser_o,   // bad_input
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_XDIV  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_TDIV  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] term_limit_q;
  logic [TOL_W-1:0] tolerance_q;

  logic [MAG_W-1:0] xmag_q, xmag_d;
  logic             xneg_q, xneg_d;
  logic [MAG_W-1:0] powmag_q, powmag_d;
  logic             powneg_q, powneg_d;
  logic [MAG_W-1:0] termmag_q, termmag_d;
  logic             termneg_q, termneg_d;
  logic             plus_q, plus_d;
  logic             invert_q, invert_d;
  logic             bad_q, bad_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_ln_q, out_ln_d;
  logic [CNT_W-1:0] out_cnt_q, out_cnt_d;
  logic        out_bad_q, out_bad_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                    in_acc, cfg_wr, keep_going;
  logic [2*MAG_W-1:0]      prod;
  logic [31:0]             v;
  logic [31:0]             vdiff;
  logic signed [SUM_W-1:0] term_s, fin_s;
  logic [SUM_W-1:0]        fin_mag;
  logic [SUM_W-1:0]        fin_shr;
  logic [SUM_W-1:0]        fin_res;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_limit_q <= TERM_LIMIT_RST;
      tolerance_q  <= TOLERANCE_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_TERM_LIMIT: term_limit_q <= pwdata[CNT_W-1:0];
        REG_TOLERANCE:  tolerance_q  <= pwdata[TOL_W-1:0];
        default:        term_limit_q <= term_limit_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TERM_LIMIT: prdata = {16'd0, term_limit_q};
      REG_TOLERANCE:  prdata = {2'd0, tolerance_q};
      default:        prdata = '0;
    endcase
  end

  // Shared units
  nls_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign prod       = powmag_q * xmag_q;
  assign v          = s_axis_tdata_i;
  assign vdiff      = v - V_ONE;
  assign in_acc     = s_axis_tvalid_i & s_axis_tready_o;
  assign keep_going = (count_q < term_limit_q) && (termmag_q >= MAG_W'(tolerance_q));
  assign term_s     = termneg_q ? -SUM_W'(termmag_q) : SUM_W'(termmag_q);

  // Final scaling: Q2.30 to Q8.24, truncated toward zero
  assign fin_s   = invert_q ? -sum_q : sum_q;
  assign fin_mag = fin_s[SUM_W-1] ? SUM_W'(-fin_s) : SUM_W'(fin_s);
  assign fin_shr = fin_mag >> (Q30_FRAC - 24);
  assign fin_res = fin_s[SUM_W-1] ? -fin_shr : fin_shr;

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    xmag_d      = xmag_q;
    xneg_d      = xneg_q;
    powmag_d    = powmag_q;
    powneg_d    = powneg_q;
    termmag_d   = termmag_q;
    termneg_d   = termneg_q;
    plus_d      = plus_q;
    invert_d    = invert_q;
    bad_d       = bad_q;
    count_d     = count_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    out_ln_d    = out_ln_q;
    out_cnt_d   = out_cnt_q;
    out_bad_d   = out_bad_q;
    div_req     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          count_d  = CNT_W'(1);
          sum_d    = '0;
          plus_d   = 1'b1;
          bad_d    = (v == 32'd0);
          invert_d = (v > V_TWO);
          if (v == 32'd0) begin
            state_d = ST_FIN;
          end else if (v > V_TWO) begin
            div_req.start    = 1'b1;
            div_req.long_div = 1'b1;
            div_req.dividend = {vdiff, 30'd0};
            div_req.divisor  = v;
            state_d          = ST_XDIV;
          end else begin
            if (v >= V_ONE) begin
              xmag_d = MAG_W'({vdiff[V_FRAC:0], 14'd0});
              xneg_d = 1'b0;
            end else begin
              xmag_d = MAG_W'({1'b0, V_ONE[V_FRAC-1:0] - v[V_FRAC-1:0], 14'd0}) |
                       (v[V_FRAC-1:0] == '0 ? MAG_W'(1) << Q30_FRAC : '0);
              xneg_d = 1'b1;
            end
            powmag_d  = xmag_d;
            powneg_d  = xneg_d;
            termmag_d = xmag_d;
            termneg_d = xneg_d;
            state_d   = ST_CHECK;
          end
        end
      end
      ST_XDIV: begin
        if (div_rsp.done) begin
          xmag_d    = div_rsp.quotient;
          xneg_d    = 1'b1;
          powmag_d  = div_rsp.quotient;
          powneg_d  = 1'b1;
          termmag_d = div_rsp.quotient;
          termneg_d = 1'b1;
          state_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (keep_going) begin
          sum_d   = sum_q + term_s;
          count_d = count_q + CNT_W'(1);
          plus_d  = ~plus_q;
          state_d = ST_MUL;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_MUL: begin
        // Advance the power, then divide it by the term index
        powmag_d         = prod[Q30_FRAC +: MAG_W];
        powneg_d         = powneg_q ^ xneg_q;
        div_req.start    = 1'b1;
        div_req.long_div = 1'b0;
        div_req.dividend = {powmag_d, 31'd0};
        div_req.divisor  = DVS_W'(count_q);
        state_d          = ST_TDIV;
      end
      ST_TDIV: begin
        if (div_rsp.done) begin
          termmag_d = div_rsp.quotient;
          termneg_d = (powneg_q != ~plus_q) && (div_rsp.quotient != '0);
          state_d   = ST_CHECK;
        end
      end
      ST_FIN: begin
        // Hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_bad_d   = bad_q;
          out_ln_d    = bad_q ? 32'd0 : fin_res[31:0];
          out_cnt_d   = bad_q ? '0 : count_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xmag_q    <= xmag_d;
    xneg_q    <= xneg_d;
    powmag_q  <= powmag_d;
    powneg_q  <= powneg_d;
    termmag_q <= termmag_d;
    termneg_q <= termneg_d;
    plus_q    <= plus_d;
    invert_q  <= invert_d;
    bad_q     <= bad_d;
    count_q   <= count_d;
    sum_q     <= sum_d;
    out_ln_q  <= out_ln_d;
    out_cnt_q <= out_cnt_d;
    out_bad_q <= out_bad_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_cnt_q, out_ln_q};
  assign m_axis_tuser_o  = out_bad_q;

`ifndef NO_ASSERTIONS
  // An accepted item always leaves the idle state
  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE) else $error("item accepted but idle");

  // The divider only finishes while the sequencer waits on it
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_XDIV || state_q == ST_TDIV))
    else $error("divider result not awaited");

  // The multiply step always hands off to the divider
  a_mul_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |=> (state_q == ST_TDIV && div_rsp.busy))
    else $error("term division not started");

  // A result is only loaded from the finish state
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result loaded out of sequence");
`endif

endmodule
